@@ src/jets_pkg.sv @@
// shared types, constants and saturation helper for the joint external torque estimator
// no dependencies; every other file in src imports this package
`timescale 1ns / 1ps

package jets_pkg;

   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 3;
   // width used for intermediate sums before saturation to 32 bits
   localparam int SAT_W     = 72;
   // register stages inside the friction datapath
   localparam int FRIC_LAT  = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESIDUAL_OFFSET  = 3'd0,
      CSR_DEADBAND_WIDTH   = 3'd1,
      CSR_COULOMB_POSITIVE = 3'd2,
      CSR_VISCOUS_POSITIVE = 3'd3,
      CSR_COULOMB_NEGATIVE = 3'd4,
      CSR_VISCOUS_NEGATIVE = 3'd5,
      CSR_INV_TRANS_SPEED  = 3'd6,
      CSR_FRICTION_ENABLE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] torque_residual;
      logic signed [DATA_W-1:0] joint_speed;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] bias_removed;
      logic signed [DATA_W-1:0] friction_estimate;
      logic signed [DATA_W-1:0] friction_removed;
      logic signed [DATA_W-1:0] external_torque;
      logic                     inside_deadband;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] residual_offset;
      logic [DATA_W-2:0]        deadband_width;
      logic signed [DATA_W-1:0] coulomb_positive;
      logic signed [DATA_W-1:0] viscous_positive;
      logic signed [DATA_W-1:0] coulomb_negative;
      logic signed [DATA_W-1:0] viscous_negative;
      logic [DATA_W-2:0]        inverse_transition_speed;
      logic                     friction_enable;
   } cfg_type;

   localparam logic signed [SAT_W-1:0] SAT_MAX =
      {{(SAT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_MIN =
      {{(SAT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (x < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/jets_csr.sv @@
// configuration register file of the torque estimator
// depends on jets_pkg for the register index codes and the cfg_type struct
`timescale 1ns / 1ps

module jets_csr #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [jets_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jets_pkg::DATA_W-1:0]         csr_data,
   output jets_pkg::cfg_type                   cfg
);
   import jets_pkg::*;

   // full blend at unit speed
   localparam logic [DATA_W-2:0] INV_SPEED_RESET = (DATA_W-1)'(1) << FRACTION_BITS;
   // only the reciprocal speed, just above the enable bit, resets nonzero
   localparam cfg_type CFG_RESET =
      cfg_type'({{(6*DATA_W-1){1'b0}}, INV_SPEED_RESET, 1'b0});

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;

   assign idx = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (idx)
            CSR_RESIDUAL_OFFSET:  cfg_in.residual_offset = csr_data;
            CSR_DEADBAND_WIDTH:   cfg_in.deadband_width = csr_data[DATA_W-2:0];
            CSR_COULOMB_POSITIVE: cfg_in.coulomb_positive = csr_data;
            CSR_VISCOUS_POSITIVE: cfg_in.viscous_positive = csr_data;
            CSR_COULOMB_NEGATIVE: cfg_in.coulomb_negative = csr_data;
            CSR_VISCOUS_NEGATIVE: cfg_in.viscous_negative = csr_data;
            CSR_INV_TRANS_SPEED:  cfg_in.inverse_transition_speed = csr_data[DATA_W-2:0];
            CSR_FRICTION_ENABLE:  cfg_in.friction_enable = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/jets_friction.sv @@
// seven stage friction datapath: coulomb plus viscous prediction scaled by a smoothstep blend
// depends on jets_pkg for cfg_type, widths and the sat32 function
`timescale 1ns / 1ps

module jets_friction #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [jets_pkg::DATA_W-1:0] joint_speed,
   input  jets_pkg::cfg_type                  cfg,
   output logic signed [jets_pkg::DATA_W-1:0] friction
);
   import jets_pkg::*;

   localparam int PRED_W = 65 - FRACTION_BITS;
   localparam int HI_W   = PRED_W - DATA_W;
   localparam int N_W    = FRACTION_BITS + 1;
   localparam int NSQ_W  = 2 * N_W;
   localparam int TMP_W  = FRACTION_BITS + 2;
   localparam int SR_W   = N_W + TMP_W;
   localparam int BL_W   = SR_W + 1 - FRACTION_BITS;
   localparam int PL_W   = BL_W + DATA_W;
   localparam int PH_W   = BL_W + 1 + HI_W;

   localparam logic [N_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [TMP_W-1:0] THREE = TMP_W'(3) << FRACTION_BITS;
   localparam logic signed [63:0] PV_HALF =
      {{(64-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
   localparam logic [NSQ_W-1:0] NSQ_HALF =
      {{(NSQ_W-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
   localparam logic [SR_W:0] SR_HALF =
      {{(SR_W+1-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
   localparam logic signed [SAT_W-1:0] TOT_HALF =
      {{(SAT_W-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

   // stage 1: speed magnitude and coefficient select
   logic [DATA_W-1:0]        spd_in, spd_ff;
   logic signed [DATA_W-1:0] visc_in, visc_ff;
   logic signed [DATA_W-1:0] coul1_in, coul1_ff;
   logic                     act1_in, act1_ff;
   logic                     positive;

   assign positive = !joint_speed[DATA_W-1];
   assign spd_in   = joint_speed[DATA_W-1] ? (~joint_speed + 1'b1) : joint_speed;
   assign visc_in  = positive ? cfg.viscous_positive : cfg.viscous_negative;
   assign coul1_in = positive ? cfg.coulomb_positive : cfg.coulomb_negative;
   assign act1_in  = cfg.friction_enable && (joint_speed != '0);

   // stage 2: viscous product and normalized speed product
   logic signed [63:0]       pv_in, pv_ff;
   logic [62:0]              np_in, np_ff;
   logic signed [DATA_W-1:0] coul2_ff;
   logic                     act2_ff;

   assign pv_in = visc_ff * $signed({1'b0, spd_ff});
   assign np_in = spd_ff * cfg.inverse_transition_speed;

   // stage 3: prediction and clamped n
   logic signed [63:0]       pv_sum, pv_rnd;
   logic signed [PRED_W-1:0] pred3_in, pred3_ff;
   logic [62:0]              n_sh;
   logic [N_W-1:0]           n_in, n_ff;
   logic                     act3_ff;

   assign pv_sum   = pv_ff + PV_HALF;
   assign pv_rnd   = pv_sum >>> FRACTION_BITS;
   assign pred3_in = PRED_W'(pv_rnd) + PRED_W'(coul2_ff);
   assign n_sh     = np_ff >> FRACTION_BITS;
   assign n_in     = (n_sh > 63'(ONE)) ? ONE : N_W'(n_sh);

   // stage 4: n squared and (3 - 2n)
   logic [NSQ_W-1:0]         nsq_in, nsq_ff;
   logic [TMP_W-1:0]         tmp_in, tmp_ff;
   logic signed [PRED_W-1:0] pred4_ff;
   logic                     act4_ff;

   assign nsq_in = n_ff * n_ff;
   assign tmp_in = THREE - (TMP_W'(n_ff) << 1);

   // stage 5: round n squared, smoothstep product
   logic [NSQ_W-1:0]         nsq_sum;
   logic [N_W-1:0]           n2;
   logic [SR_W-1:0]          sraw_in, sraw_ff;
   logic signed [PRED_W-1:0] pred5_ff;
   logic                     act5_ff;

   assign nsq_sum = nsq_ff + NSQ_HALF;
   assign n2      = nsq_sum[FRACTION_BITS +: N_W];
   assign sraw_in = n2 * tmp_ff;

   // stage 6: round blend, partial products against the prediction halves
   logic [SR_W:0]            sr_sum;
   logic [BL_W-1:0]          blend;
   logic [PL_W-1:0]          plp_in, plp_ff;
   logic signed [PH_W-1:0]   php_in, php_ff;
   logic                     act6_ff;

   assign sr_sum = {1'b0, sraw_ff} + SR_HALF;
   assign blend  = sr_sum[SR_W:FRACTION_BITS];
   assign plp_in = blend * pred5_ff[DATA_W-1:0];
   assign php_in = $signed({1'b0, blend}) * $signed(pred5_ff[PRED_W-1:DATA_W]);

   // stage 7: recombine, round and saturate
   logic signed [SAT_W-1:0]  ph_ext, pl_ext, tot, tot_rnd;
   logic signed [DATA_W-1:0] fric_in, fric_ff;

   assign ph_ext  = SAT_W'(php_ff);
   assign pl_ext  = SAT_W'(plp_ff);
   assign tot     = (ph_ext <<< DATA_W) + pl_ext + TOT_HALF;
   assign tot_rnd = tot >>> FRACTION_BITS;
   assign fric_in = act6_ff ? sat32(tot_rnd) : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         spd_ff   <= spd_in;
         visc_ff  <= visc_in;
         coul1_ff <= coul1_in;
         act1_ff  <= act1_in;

         pv_ff    <= pv_in;
         np_ff    <= np_in;
         coul2_ff <= coul1_ff;
         act2_ff  <= act1_ff;

         pred3_ff <= pred3_in;
         n_ff     <= n_in;
         act3_ff  <= act2_ff;

         nsq_ff   <= nsq_in;
         tmp_ff   <= tmp_in;
         pred4_ff <= pred3_ff;
         act4_ff  <= act3_ff;

         sraw_ff  <= sraw_in;
         pred5_ff <= pred4_ff;
         act5_ff  <= act4_ff;

         plp_ff   <= plp_in;
         php_ff   <= php_in;
         act6_ff  <= act5_ff;

         fric_ff  <= fric_in;
      end
   end

   assign friction = fric_ff;

endmodule

@@ src/jets_deadband.sv @@
// deadband stage and output register of the torque estimator
// depends on jets_pkg for rsp_type and widths
`timescale 1ns / 1ps

module jets_deadband (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [jets_pkg::DATA_W-1:0] bias_removed,
   input  logic signed [jets_pkg::DATA_W-1:0] friction_estimate,
   input  logic signed [jets_pkg::DATA_W-1:0] friction_removed,
   input  logic [jets_pkg::DATA_W-2:0]        deadband_width,
   output jets_pkg::rsp_type                  rsp
);
   import jets_pkg::*;

   logic              negative;
   logic [DATA_W-1:0] mag;
   logic [DATA_W-1:0] shrunk;
   rsp_type           rsp_in, rsp_ff;

   assign negative = friction_removed[DATA_W-1];
   // magnitude of the most negative value still fits unsigned
   assign mag      = negative ? (~friction_removed + 1'b1) : friction_removed;
   assign shrunk   = mag - DATA_W'(deadband_width);

   always_comb begin
      rsp_in.bias_removed      = bias_removed;
      rsp_in.friction_estimate = friction_estimate;
      rsp_in.friction_removed  = friction_removed;
      rsp_in.external_torque   = friction_removed;
      rsp_in.inside_deadband   = 1'b0;
      if (deadband_width != '0) begin
         if (mag <= DATA_W'(deadband_width)) begin
            rsp_in.external_torque = '0;
            rsp_in.inside_deadband = 1'b1;
         end else begin
            rsp_in.external_torque = negative ? (~shrunk + 1'b1) : shrunk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ src/joint_external_torque_estimator.sv @@
// joint external torque estimator, one joint channel
// throughput: one item per cycle while the output item is not waiting on rsp_ready
// the nine stages advance together and hold while the output item waits on rsp_ready
// reset clears all stage valid bits and loads the configuration registers with their reset values
// depends on jets_pkg, jets_csr, jets_friction and jets_deadband
`timescale 1ns / 1ps

module joint_external_torque_estimator #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  jets_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output jets_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jets_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jets_pkg::DATA_W-1:0]    csr_data
);
   import jets_pkg::*;

   localparam int DEPTH = FRIC_LAT + 2;

   cfg_type                  cfg;
   logic                     adv;
   logic [DEPTH-1:0]         valid_ff;
   logic signed [DATA_W-1:0] biased_in;
   logic signed [DATA_W-1:0] biased_ff [FRIC_LAT];
   logic signed [DATA_W-1:0] friction;
   logic signed [DATA_W-1:0] rem_in, rem_ff;
   logic signed [DATA_W-1:0] bias8_ff, fric8_ff;

   assign csr_ready = 1'b1;

   jets_csr #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // whole pipeline moves unless the output item is stuck
   assign adv       = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   assign biased_in = sat32(SAT_W'(req_data.torque_residual) - SAT_W'(cfg.residual_offset));

   // bias-removed value waits alongside the friction datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         biased_ff[0] <= biased_in;
         for (int i = 1; i < FRIC_LAT; i++) begin
            biased_ff[i] <= biased_ff[i-1];
         end
      end
   end

   jets_friction #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_friction (
      .clock       (clock),
      .en          (adv),
      .joint_speed (req_data.joint_speed),
      .cfg         (cfg),
      .friction    (friction)
   );

   assign rem_in = sat32(SAT_W'(biased_ff[FRIC_LAT-1]) - SAT_W'(friction));

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff   <= rem_in;
         bias8_ff <= biased_ff[FRIC_LAT-1];
         fric8_ff <= friction;
      end
   end

   jets_deadband u_deadband (
      .clock             (clock),
      .en                (adv),
      .bias_removed      (bias8_ff),
      .friction_estimate (fric8_ff),
      .friction_removed  (rem_ff),
      .deadband_width    (cfg.deadband_width),
      .rsp               (rsp_data)
   );

endmodule
